/* hdl/pitl_pkg.sv */
// Shared types, constants and helpers for the palette inverse temperature lookup.
`default_nettype none

package pitl_pkg;

  localparam int IDX_W   = 8;
  localparam int COLOR_W = 8;
  localparam int RAW_W   = 14;
  localparam int TEMP_W  = 11;
  localparam int PCT_W   = 7;
  localparam int DIST_W  = 10;
  localparam int PROD_W  = 22;
  localparam int Q_W     = 15;
  localparam int RS_W    = 17;
  localparam int TD_W    = 15;
  localparam int TQ_W    = 10;
  localparam int PZ_W    = 15;
  localparam int MUL_W   = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [RAW_W-1:0] RAW_MAX     = 14'h3FFF;
  localparam logic [RAW_W-1:0] TEMP_OFFSET = 14'd7900;
  localparam logic [RAW_W-1:0] MIN_RAW_RST = 14'd7900;
  localparam logic [RAW_W-1:0] MAX_RAW_RST = 14'd8300;

  localparam logic [COLOR_W-1:0] INDEX_SCALE = 8'd255;

  // floor(x / 255) estimate, low by at most one, for x below 2^22
  localparam logic [MUL_W-1:0] DIV255_LO    = 16'd32896;
  // exact floor(z / 255) for z below 2^15
  localparam logic [MUL_W-1:0] DIV255_HI    = 16'd32897;
  localparam int               DIV255_SHIFT = 23;
  // exact floor(x / 15) for x below 2^14
  localparam logic [MUL_W-1:0] DIV15_MUL    = 16'd34953;
  localparam int               DIV15_SHIFT  = 19;

  localparam logic [6:0] PCT_SCALE = 7'd100;
  localparam logic [6:0] PCT_BIAS  = 7'd127;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_MIN_RAW = 1'b0,
    REG_MAX_RAW = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic               is_query;
    logic [IDX_W-1:0]   entry_index;
    color_t             color;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_DIVE,
    ST_DIVC,
    ST_CLAMP,
    ST_TEMP,
    ST_PCT,
    ST_DONE
  } back_state_t;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

/* hdl/pitl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pitl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 255
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/pitl_front.sv */
// Front end: accepts requests, drops out-of-range loads, forwards the rest to the queue.
`default_nettype none

module pitl_front #(
  parameter int PALETTE_ENTRIES = 255
) (
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_command,
  input  wire logic [pitl_pkg::IDX_W-1:0]     in_entry_index,
  input  wire logic [pitl_pkg::COLOR_W-1:0]   in_red,
  input  wire logic [pitl_pkg::COLOR_W-1:0]   in_green,
  input  wire logic [pitl_pkg::COLOR_W-1:0]   in_blue,
  input  wire pitl_pkg::q_status_t            q_status,
  output logic                                push,
  output pitl_pkg::req_t                      push_req
);

  logic is_query;
  logic in_range;
  logic keep;

  always_comb begin
    is_query = (in_command == pitl_pkg::CMD_QUERY);
    in_range = ({1'b0, in_entry_index} < (pitl_pkg::IDX_W + 1)'(PALETTE_ENTRIES));
    keep     = is_query || in_range;

    push_req.is_query    = is_query;
    push_req.entry_index = in_entry_index;
    push_req.color.red   = in_red;
    push_req.color.green = in_green;
    push_req.color.blue  = in_blue;

    in_stall = q_status.full;
    push     = in_valid && !q_status.full && keep;
  end

endmodule

`default_nettype wire

/* hdl/pitl_queue.sv */
// Short request queue between the front end and the back end.
`default_nettype none

module pitl_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pitl_pkg::req_t  push_req,
  input  wire logic            pop,
  output pitl_pkg::req_t       head,
  output pitl_pkg::q_status_t  status
);

  localparam int PTR_W = (pitl_pkg::QUEUE_DEPTH > 1) ? $clog2(pitl_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pitl_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(pitl_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(pitl_pkg::QUEUE_DEPTH);

  pitl_pkg::req_t   slot_r [pitl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    status.full  = (count_r == CNT_FULL);
    status.empty = (count_r == '0);
    head         = slot_r[rd_ptr_r];

    do_push = push && !status.full;
    do_pop  = pop && !status.empty;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

`default_nettype wire

/* hdl/pitl_back.sv */
// Back end: writes palette entries, scans the palette for a query and scales the result.
`default_nettype none

module pitl_back #(
  parameter int PALETTE_ENTRIES = 255
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire pitl_pkg::q_status_t                    q_status,
  input  wire pitl_pkg::req_t                         head,
  output logic                                        pop,
  output logic                                        ram_we,
  output logic [$clog2(PALETTE_ENTRIES)-1:0]          ram_waddr,
  output pitl_pkg::color_t                            ram_wdata,
  output logic [$clog2(PALETTE_ENTRIES)-1:0]          ram_raddr,
  input  wire pitl_pkg::color_t                       ram_rdata,
  input  wire logic [pitl_pkg::RAW_W-1:0]             min_raw,
  input  wire logic [pitl_pkg::RAW_W-1:0]             max_raw,
  input  wire logic                                   out_stall,
  output logic                                        out_valid,
  output logic [pitl_pkg::IDX_W-1:0]                  out_nearest_index,
  output logic [pitl_pkg::RAW_W-1:0]                  out_raw_value,
  output logic signed [pitl_pkg::TEMP_W-1:0]          out_temperature_degrees,
  output logic [pitl_pkg::PCT_W-1:0]                  out_percent
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(PALETTE_ENTRIES - 1);
  localparam int EST_W  = pitl_pkg::PROD_W + pitl_pkg::MUL_W;
  localparam int TP_W   = pitl_pkg::RAW_W + pitl_pkg::MUL_W;
  localparam int PP_W   = pitl_pkg::PZ_W + pitl_pkg::MUL_W;

  pitl_pkg::back_state_t state_r, state_nxt;

  logic [AW-1:0]                       rd_cnt_r, rd_cnt_nxt;
  logic [AW-1:0]                       cmp_idx_r, cmp_idx_nxt;
  logic                                rd_vld_r, rd_vld_nxt;
  pitl_pkg::color_t                    pix_r, pix_nxt;
  logic [AW-1:0]                       best_r, best_nxt;
  logic [pitl_pkg::DIST_W-1:0]         best_dist_r, best_dist_nxt;
  logic                                neg_r, neg_nxt;
  logic [pitl_pkg::PROD_W-1:0]         mag_r, mag_nxt;
  logic [pitl_pkg::Q_W-1:0]            q_r, q_nxt;
  logic [pitl_pkg::RAW_W-1:0]          raw_r, raw_nxt;
  logic signed [pitl_pkg::TEMP_W-1:0]  temp_r, temp_nxt;
  logic [pitl_pkg::PCT_W-1:0]          pct_r, pct_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [pitl_pkg::IDX_W-1:0]          out_idx_r;
  logic [pitl_pkg::RAW_W-1:0]          out_raw_r;
  logic signed [pitl_pkg::TEMP_W-1:0]  out_temp_r;
  logic [pitl_pkg::PCT_W-1:0]          out_pct_r;

  logic                                start_query;
  logic                                out_load;
  logic                                scan_en;

  logic [pitl_pkg::IDX_W-1:0]          best_idx;
  logic [pitl_pkg::DIST_W-1:0]         color_dist;
  logic [pitl_pkg::RAW_W-1:0]          diff_mag;
  logic [EST_W-1:0]                    est;
  logic [pitl_pkg::PROD_W-1:0]         q255;
  logic [pitl_pkg::PROD_W-1:0]         rem;
  logic [pitl_pkg::PROD_W-1:0]         rem_fix;
  logic [pitl_pkg::Q_W-1:0]            q_fix;
  logic signed [pitl_pkg::RS_W-1:0]    q_s;
  logic signed [pitl_pkg::RS_W-1:0]    raw_s;
  logic signed [pitl_pkg::TD_W-1:0]    t_s;
  logic [pitl_pkg::RAW_W-1:0]          t_mag;
  logic [TP_W-1:0]                     t_prod;
  logic [pitl_pkg::TQ_W-1:0]           t_q;
  logic [pitl_pkg::PZ_W-1:0]           pz;
  logic [PP_W-1:0]                     p_prod;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pitl_pkg::ST_IDLE: begin
        if (!q_status.empty && head.is_query) begin
          state_nxt = pitl_pkg::ST_SCAN;
        end
      end
      pitl_pkg::ST_SCAN: begin
        if (rd_cnt_r == LAST_ENTRY) begin
          state_nxt = pitl_pkg::ST_DRAIN;
        end
      end
      pitl_pkg::ST_DRAIN: state_nxt = pitl_pkg::ST_MUL;
      pitl_pkg::ST_MUL:   state_nxt = pitl_pkg::ST_DIVE;
      pitl_pkg::ST_DIVE:  state_nxt = pitl_pkg::ST_DIVC;
      pitl_pkg::ST_DIVC:  state_nxt = pitl_pkg::ST_CLAMP;
      pitl_pkg::ST_CLAMP: state_nxt = pitl_pkg::ST_TEMP;
      pitl_pkg::ST_TEMP:  state_nxt = pitl_pkg::ST_PCT;
      pitl_pkg::ST_PCT:   state_nxt = pitl_pkg::ST_DONE;
      pitl_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = pitl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pitl_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop         = 1'b0;
    ram_we      = 1'b0;
    start_query = 1'b0;
    out_load    = 1'b0;
    scan_en     = 1'b0;
    case (state_r)
      pitl_pkg::ST_IDLE: begin
        pop         = !q_status.empty;
        ram_we      = !q_status.empty && !head.is_query;
        start_query = !q_status.empty && head.is_query;
      end
      pitl_pkg::ST_SCAN: scan_en = 1'b1;
      pitl_pkg::ST_DONE: out_load = !out_valid_r || !out_stall;
      default: begin
        pop = 1'b0;
      end
    endcase
    ram_waddr = head.entry_index[AW-1:0];
    ram_wdata = head.color;
    ram_raddr = rd_cnt_r;
  end

  // datapath
  always_comb begin
    best_idx = pitl_pkg::IDX_W'(best_r);
    color_dist = pitl_pkg::DIST_W'(pitl_pkg::abs_diff(ram_rdata.red, pix_r.red))
               + pitl_pkg::DIST_W'(pitl_pkg::abs_diff(ram_rdata.green, pix_r.green))
               + pitl_pkg::DIST_W'(pitl_pkg::abs_diff(ram_rdata.blue, pix_r.blue));

    diff_mag = (max_raw >= min_raw) ? (max_raw - min_raw) : (min_raw - max_raw);

    est = EST_W'(mag_r) * EST_W'(pitl_pkg::DIV255_LO);

    q255 = pitl_pkg::PROD_W'({q_r, 8'd0}) - pitl_pkg::PROD_W'(q_r);
    rem  = mag_r - q255;
    if (rem >= pitl_pkg::PROD_W'(pitl_pkg::INDEX_SCALE)) begin
      q_fix   = q_r + 1'b1;
      rem_fix = rem - pitl_pkg::PROD_W'(pitl_pkg::INDEX_SCALE);
    end else begin
      q_fix   = q_r;
      rem_fix = rem;
    end

    q_s = $signed({2'b00, q_r});
    if (neg_r) begin
      q_s = -q_s;
    end
    raw_s = $signed({3'b000, min_raw}) + q_s;

    t_s   = $signed({1'b0, raw_r}) - $signed({1'b0, pitl_pkg::TEMP_OFFSET});
    t_mag = (t_s < 0) ? pitl_pkg::RAW_W'(-t_s) : pitl_pkg::RAW_W'(t_s);
    t_prod = TP_W'(t_mag) * TP_W'(pitl_pkg::DIV15_MUL);
    t_q    = t_prod[pitl_pkg::DIV15_SHIFT +: pitl_pkg::TQ_W];

    pz     = pitl_pkg::PZ_W'(best_idx) * pitl_pkg::PZ_W'(pitl_pkg::PCT_SCALE)
           + pitl_pkg::PZ_W'(pitl_pkg::PCT_BIAS);
    p_prod = PP_W'(pz) * PP_W'(pitl_pkg::DIV255_HI);

    rd_cnt_nxt    = rd_cnt_r;
    cmp_idx_nxt   = rd_cnt_r;
    rd_vld_nxt    = scan_en;
    pix_nxt       = pix_r;
    best_nxt      = best_r;
    best_dist_nxt = best_dist_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    q_nxt         = q_r;
    raw_nxt       = raw_r;
    temp_nxt      = temp_r;
    pct_nxt       = pct_r;

    if (start_query) begin
      pix_nxt       = head.color;
      rd_cnt_nxt    = '0;
      best_nxt      = '0;
      best_dist_nxt = '1;
    end
    if (scan_en) begin
      rd_cnt_nxt = rd_cnt_r + 1'b1;
    end
    if (rd_vld_r && (color_dist < best_dist_r)) begin
      best_dist_nxt = color_dist;
      best_nxt      = cmp_idx_r;
    end

    case (state_r)
      pitl_pkg::ST_MUL: begin
        neg_nxt = (max_raw < min_raw);
        mag_nxt = pitl_pkg::PROD_W'(best_idx) * pitl_pkg::PROD_W'(diff_mag);
      end
      pitl_pkg::ST_DIVE: begin
        q_nxt = est[pitl_pkg::DIV255_SHIFT +: pitl_pkg::Q_W];
      end
      pitl_pkg::ST_DIVC: begin
        // round a negative quotient toward minus infinity
        q_nxt = q_fix + pitl_pkg::Q_W'(neg_r && (rem_fix != '0));
      end
      pitl_pkg::ST_CLAMP: begin
        if (raw_s < 0) begin
          raw_nxt = '0;
        end else if (raw_s > $signed({3'b000, pitl_pkg::RAW_MAX})) begin
          raw_nxt = pitl_pkg::RAW_MAX;
        end else begin
          raw_nxt = raw_s[pitl_pkg::RAW_W-1:0];
        end
      end
      pitl_pkg::ST_TEMP: begin
        if (t_s < 0) begin
          temp_nxt = -$signed({1'b0, t_q});
        end else begin
          temp_nxt = $signed({1'b0, t_q});
        end
      end
      pitl_pkg::ST_PCT: begin
        pct_nxt = p_prod[pitl_pkg::DIV255_SHIFT +: pitl_pkg::PCT_W];
      end
      default: begin
        neg_nxt = neg_r;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pitl_pkg::ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r    <= rd_cnt_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    pix_r       <= pix_nxt;
    best_r      <= best_nxt;
    best_dist_r <= best_dist_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    q_r         <= q_nxt;
    raw_r       <= raw_nxt;
    temp_r      <= temp_nxt;
    pct_r       <= pct_nxt;
    if (out_load) begin
      out_idx_r  <= best_idx;
      out_raw_r  <= raw_r;
      out_temp_r <= temp_r;
      out_pct_r  <= pct_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_nearest_index       = out_idx_r;
  assign out_raw_value           = out_raw_r;
  assign out_temperature_degrees = out_temp_r;
  assign out_percent             = out_pct_r;

endmodule

`default_nettype wire

/* hdl/palette_inverse_temperature_lookup.sv */
// Top level of the palette inverse temperature lookup.
//
// Load requests (command 0) write one 24-bit RGB entry of the palette RAM;
// loads whose entry_index is not below PALETTE_ENTRIES are dropped. Query
// requests (command 1) return the first palette entry with the smallest sum
// of absolute channel differences, the raw value min_raw + index*(max_raw -
// min_raw)/255 rounded down and clamped to 14 bits, (raw - 7900)/15 truncated
// toward zero, and index*100/255 rounded. Entries must be loaded before a
// query reads them; the palette is not cleared at reset. A two-deep request
// queue sits between the input port and the execution engine, and results
// leave through an output register, so requests keep being accepted while a
// result waits. The engine retires a load as it dispatches it. A query is
// dispatched, then reads each palette entry in turn from the single RAM read
// port, lets the last read land, runs six scaling steps and hands off; the
// hand-off stretches while the previous result is still stalled.
// min_raw (address 0) and max_raw (address 4) reset to 7900 and 8300 and must
// only be written while no query is in progress.
`default_nettype none

module palette_inverse_temperature_lookup #(
  parameter int PALETTE_ENTRIES = 255
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_command,
  input  wire logic [pitl_pkg::IDX_W-1:0]           in_entry_index,
  input  wire logic [pitl_pkg::COLOR_W-1:0]         in_red,
  input  wire logic [pitl_pkg::COLOR_W-1:0]         in_green,
  input  wire logic [pitl_pkg::COLOR_W-1:0]         in_blue,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [pitl_pkg::IDX_W-1:0]                out_nearest_index,
  output logic [pitl_pkg::RAW_W-1:0]                out_raw_value,
  output logic signed [pitl_pkg::TEMP_W-1:0]        out_temperature_degrees,
  output logic [pitl_pkg::PCT_W-1:0]                out_percent,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pitl_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [pitl_pkg::DATA_W-1:0]          pwdata,
  output logic [pitl_pkg::DATA_W-1:0]               prdata,
  output logic                                      pready
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [pitl_pkg::RAW_W-1:0] min_raw_r, min_raw_nxt;
  logic [pitl_pkg::RAW_W-1:0] max_raw_r, max_raw_nxt;
  logic                       cfg_wr;
  pitl_pkg::reg_idx_t         reg_sel;

  logic                       push;
  pitl_pkg::req_t             push_req;
  logic                       pop;
  pitl_pkg::req_t             head;
  pitl_pkg::q_status_t        q_status;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  pitl_pkg::color_t           ram_wdata;
  logic [AW-1:0]              ram_raddr;
  pitl_pkg::color_t           ram_rdata;

  always_comb begin
    pready  = 1'b1;
    cfg_wr  = psel && penable && pwrite && pready;
    reg_sel = pitl_pkg::reg_idx_t'(paddr[2]);

    min_raw_nxt = min_raw_r;
    max_raw_nxt = max_raw_r;
    prdata      = '0;
    case (reg_sel)
      pitl_pkg::REG_MIN_RAW: begin
        prdata = pitl_pkg::DATA_W'(min_raw_r);
        if (cfg_wr) begin
          min_raw_nxt = pwdata[pitl_pkg::RAW_W-1:0];
        end
      end
      pitl_pkg::REG_MAX_RAW: begin
        prdata = pitl_pkg::DATA_W'(max_raw_r);
        if (cfg_wr) begin
          max_raw_nxt = pwdata[pitl_pkg::RAW_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_raw_r <= pitl_pkg::MIN_RAW_RST;
      max_raw_r <= pitl_pkg::MAX_RAW_RST;
    end else begin
      min_raw_r <= min_raw_nxt;
      max_raw_r <= max_raw_nxt;
    end
  end

  pitl_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .q_status       (q_status),
    .push           (push),
    .push_req       (push_req)
  );

  pitl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  pitl_ram #(
    .WIDTH($bits(pitl_pkg::color_t)),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  pitl_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_status                (q_status),
    .head                    (head),
    .pop                     (pop),
    .ram_we                  (ram_we),
    .ram_waddr               (ram_waddr),
    .ram_wdata               (ram_wdata),
    .ram_raddr               (ram_raddr),
    .ram_rdata               (ram_rdata),
    .min_raw                 (min_raw_r),
    .max_raw                 (max_raw_r),
    .out_stall               (out_stall),
    .out_valid               (out_valid),
    .out_nearest_index       (out_nearest_index),
    .out_raw_value           (out_raw_value),
    .out_temperature_degrees (out_temperature_degrees),
    .out_percent             (out_percent)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the palette lookup: random palette loads and color queries.
module testbench;

  localparam int PALETTE_ENTRIES = 255;
  localparam int NUM_PHASES      = 8;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int SETTLE_CYCLES   = PALETTE_ENTRIES + 50;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int INDEX_SPAN      = 255;
  localparam int RAW_CEILING     = 16383;
  localparam int DEGREE_BASE     = 7900;
  localparam int DEGREE_STEP     = 15;

  typedef struct packed {
    pitl_pkg::cmd_t                   command;
    logic [pitl_pkg::IDX_W-1:0]       entry_index;
    logic [pitl_pkg::COLOR_W-1:0]     red;
    logic [pitl_pkg::COLOR_W-1:0]     green;
    logic [pitl_pkg::COLOR_W-1:0]     blue;
  } pixel_request_t;

  typedef struct {
    logic [pitl_pkg::IDX_W-1:0]         nearest;
    logic [pitl_pkg::RAW_W-1:0]         raw;
    logic signed [pitl_pkg::TEMP_W-1:0] degrees;
    logic [pitl_pkg::PCT_W-1:0]         pct;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               in_command = 1'b0;
  logic [pitl_pkg::IDX_W-1:0]         in_entry_index = '0;
  logic [pitl_pkg::COLOR_W-1:0]       in_red = '0;
  logic [pitl_pkg::COLOR_W-1:0]       in_green = '0;
  logic [pitl_pkg::COLOR_W-1:0]       in_blue = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [pitl_pkg::IDX_W-1:0]         out_nearest_index;
  logic [pitl_pkg::RAW_W-1:0]         out_raw_value;
  logic signed [pitl_pkg::TEMP_W-1:0] out_temperature_degrees;
  logic [pitl_pkg::PCT_W-1:0]         out_percent;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [pitl_pkg::ADDR_W-1:0]        paddr = '0;
  logic [pitl_pkg::DATA_W-1:0]        pwdata = '0;
  logic [pitl_pkg::DATA_W-1:0]        prdata;
  logic                               pready;

  pixel_request_t pending_requests[$];
  pixel_request_t current_req;
  lookup_result_t expected_lookups[$];
  lookup_result_t observed_lookup;
  lookup_result_t wanted_lookup;
  logic [pitl_pkg::COLOR_W-1:0] palette_shadow [PALETTE_ENTRIES][3];
  logic [pitl_pkg::RAW_W-1:0] min_raw_cfg = pitl_pkg::MIN_RAW_RST;
  logic [pitl_pkg::RAW_W-1:0] max_raw_cfg = pitl_pkg::MAX_RAW_RST;

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_cycles = 0;
  logic hold_request = 1'b0;
  logic hold_used = 1'b0;
  logic sender_gaps = 1'b1;
  logic receiver_gaps = 1'b1;
  int mismatch_count = 0;

  palette_inverse_temperature_lookup #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_entry_index(in_entry_index),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_nearest_index(out_nearest_index),
    .out_raw_value(out_raw_value),
    .out_temperature_degrees(out_temperature_degrees),
    .out_percent(out_percent),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return $urandom_range(1, 3);
    end else if (pick < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(40, 300);
  endfunction

  function automatic lookup_result_t predict_lookup(pixel_request_t rq);
    lookup_result_t res;
    int px [3];
    int i, c, color_dist, best_dist, best, chan_diff, span, prod, step, raw, degrees;
    px[0] = rq.red;
    px[1] = rq.green;
    px[2] = rq.blue;
    best = 0;
    best_dist = 32'h7fffffff;
    for (i = 0; i < PALETTE_ENTRIES; i++) begin
      color_dist = 0;
      for (c = 0; c < 3; c++) begin
        chan_diff = int'(palette_shadow[i][c]) - px[c];
        color_dist += (chan_diff < 0) ? -chan_diff : chan_diff;
      end
      if (color_dist < best_dist) begin
        best_dist = color_dist;
        best = i;
      end
    end
    span = int'(max_raw_cfg) - int'(min_raw_cfg);
    prod = best * span;
    step = (prod >= 0) ? prod / INDEX_SPAN : -((-prod + INDEX_SPAN - 1) / INDEX_SPAN);
    raw = int'(min_raw_cfg) + step;
    if (raw < 0) begin
      raw = 0;
    end else if (raw > RAW_CEILING) begin
      raw = RAW_CEILING;
    end
    degrees = (raw - DEGREE_BASE) / DEGREE_STEP;
    res.nearest = best[pitl_pkg::IDX_W-1:0];
    res.raw = raw[pitl_pkg::RAW_W-1:0];
    res.degrees = degrees[pitl_pkg::TEMP_W-1:0];
    res.pct = pitl_pkg::PCT_W'((best * 200 + INDEX_SPAN) / (2 * INDEX_SPAN));
    return res;
  endfunction

  // request driver and prediction at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (current_req.command == pitl_pkg::CMD_LOAD) begin
          if (current_req.entry_index < PALETTE_ENTRIES) begin
            palette_shadow[current_req.entry_index][0] = current_req.red;
            palette_shadow[current_req.entry_index][1] = current_req.green;
            palette_shadow[current_req.entry_index][2] = current_req.blue;
          end
        end else begin
          expected_lookups.push_back(predict_lookup(current_req));
        end
        if (sender_gaps && $urandom_range(0, 2) == 0) begin
          gap_left = idle_length();
        end
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          current_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_command <= current_req.command;
          in_entry_index <= current_req.entry_index;
          in_red <= current_req.red;
          in_green <= current_req.green;
          in_blue <= current_req.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_used <= 1'b0;
    end else if (hold_request && !hold_used) begin
      hold_cycles <= HOLD_OFF_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // result monitor and stall generation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        observed_lookup.nearest = out_nearest_index;
        observed_lookup.raw = out_raw_value;
        observed_lookup.degrees = out_temperature_degrees;
        observed_lookup.pct = out_percent;
        if (expected_lookups.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected lookup result: idx %0d raw %0d deg %0d pct %0d",
                     observed_lookup.nearest, observed_lookup.raw,
                     observed_lookup.degrees, observed_lookup.pct);
          end
        end else begin
          wanted_lookup = expected_lookups.pop_front();
          if (observed_lookup.nearest !== wanted_lookup.nearest ||
              observed_lookup.raw !== wanted_lookup.raw ||
              observed_lookup.degrees !== wanted_lookup.degrees ||
              observed_lookup.pct !== wanted_lookup.pct) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("lookup mismatch: expected idx %0d raw %0d deg %0d pct %0d,",
                       wanted_lookup.nearest, wanted_lookup.raw,
                       wanted_lookup.degrees, wanted_lookup.pct);
              $display("  got idx %0d raw %0d deg %0d pct %0d",
                       observed_lookup.nearest, observed_lookup.raw,
                       observed_lookup.degrees, observed_lookup.pct);
            end
          end
        end
      end
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = idle_length() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_request(pitl_pkg::cmd_t cmd, int idx, int r, int g, int b);
    pixel_request_t rq;
    rq.command = cmd;
    rq.entry_index = pitl_pkg::IDX_W'(idx);
    rq.red = pitl_pkg::COLOR_W'(r);
    rq.green = pitl_pkg::COLOR_W'(g);
    rq.blue = pitl_pkg::COLOR_W'(b);
    pending_requests.push_back(rq);
  endtask

  task automatic write_reg(pitl_pkg::reg_idx_t which, int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= pitl_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == pitl_pkg::REG_MIN_RAW) begin
      min_raw_cfg = pitl_pkg::RAW_W'(value);
    end else begin
      max_raw_cfg = pitl_pkg::RAW_W'(value);
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_lookups.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int p, i, sel;
    int min_plan [NUM_PHASES];
    int max_plan [NUM_PHASES];
    min_plan = '{7900, 0, 16383, 5000, 16383, 0, 0, 0};
    max_plan = '{8300, 16383, 0, 5000, 16383, 0, 0, 0};
    for (p = 6; p < NUM_PHASES; p++) begin
      min_plan[p] = $urandom_range(0, RAW_CEILING);
      max_plan[p] = $urandom_range(0, RAW_CEILING);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill every entry before the first query
    for (i = 0; i < PALETTE_ENTRIES; i++) begin
      queue_request(pitl_pkg::CMD_LOAD, i, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
    end
    queue_request(pitl_pkg::CMD_LOAD, 17, 8'h5A, 8'hA5, 8'h3C);
    queue_request(pitl_pkg::CMD_LOAD, 130, 8'h5A, 8'hA5, 8'h3C);
    queue_request(pitl_pkg::CMD_LOAD, 200, 8'h80, 8'h80, 8'h80);
    queue_request(pitl_pkg::CMD_LOAD, 201, 8'h84, 8'h80, 8'h80);
    queue_request(pitl_pkg::CMD_LOAD, 255, 8'h12, 8'h34, 8'h56);
    queue_request(pitl_pkg::CMD_QUERY, 0, 8'h5A, 8'hA5, 8'h3C);
    queue_request(pitl_pkg::CMD_QUERY, 255, 8'h82, 8'h80, 8'h80);
    queue_request(pitl_pkg::CMD_QUERY, 128, 8'h12, 8'h34, 8'h56);
    queue_request(pitl_pkg::CMD_QUERY, 0, 8'hFF, 8'h00, 8'hFF);
    queue_request(pitl_pkg::CMD_QUERY, 0, 8'h00, 8'hFF, 8'h00);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        write_reg(pitl_pkg::REG_MIN_RAW, min_plan[p]);
        write_reg(pitl_pkg::REG_MAX_RAW, max_plan[p]);
        @(negedge clk);
      end
      sender_gaps <= (p != 1 && p != 2);
      receiver_gaps <= (p != 2);
      if (p == 1) begin
        hold_request <= 1'b1;
      end
      queue_request(pitl_pkg::CMD_LOAD, 0, 8'h00, 8'h00, 8'h00);
      queue_request(pitl_pkg::CMD_LOAD, PALETTE_ENTRIES - 1, 8'hFF, 8'hFF, 8'hFF);
      queue_request(pitl_pkg::CMD_QUERY, 0, 8'h00, 8'h00, 8'h00);
      queue_request(pitl_pkg::CMD_QUERY, 0, 8'hFF, 8'hFF, 8'hFF);
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          queue_request(pitl_pkg::CMD_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
        end else if (sel < 96) begin
          queue_request(pitl_pkg::CMD_LOAD, $urandom_range(0, PALETTE_ENTRIES - 1),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
        end else begin
          queue_request(pitl_pkg::CMD_LOAD, $urandom_range(PALETTE_ENTRIES, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
        end
      end
    end
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS palette_inverse_temperature_lookup");
    end else begin
      $display("FAIL palette_inverse_temperature_lookup");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("FAIL palette_inverse_temperature_lookup");
    $finish;
  end

endmodule

/* sim.f */
hdl/pitl_pkg.sv
hdl/pitl_ram.sv
hdl/pitl_front.sv
hdl/pitl_queue.sv
hdl/pitl_back.sv
hdl/palette_inverse_temperature_lookup.sv
sim/testbench.sv
